>>> src/bpa_pkg.sv
package bpa_pkg;

  localparam int MaxPages  = 4096;
  localparam int PageShift = 12;
  localparam int AddrW     = 48;
  localparam int FrameW    = 36;
  localparam int CountW    = 13;
  localparam int EndW      = CountW + 1;
  localparam int WordW     = 64;
  localparam int MapWords  = MaxPages / WordW;
  localparam int BitIdxW   = $clog2(WordW);
  localparam int WordIdxW  = $clog2(MapWords);
  localparam int PageIdxW  = WordIdxW + BitIdxW;
  localparam int StatusW   = 2;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = FrameW;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_MISALIGNED = 2'd2,
    ST_RANGE      = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_FRAME = 2'd0,
    CFG_TOTAL_PAGES = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    RES_OK_ALLOC,
    RES_OK_FREE,
    RES_NO_SPACE,
    RES_MISALIGNED,
    RES_RANGE
  } res_e;

  typedef struct packed {
    logic load;
    logic init_alloc;
    logic wrap;
    logic rd;
    logic scan_step;
    logic save_off;
    logic init_mark;
    logic calc_rel;
    logic init_free;
    logic wr;
    logic res_set;
    res_e res_code;
    logic out_load;
  } bpa_cmd_t;

  typedef struct packed {
    logic op_free;
    logic n_ge_total;
    logic fits;
    logic ptr_lt_end;
    logic wrap_ok;
    logic misaligned;
    logic out_of_range;
    logic out_busy;
  } bpa_stat_t;

endpackage

>>> src/bitmap_page_allocator.sv
// Next-fit page allocator over a 4096-page used bitmap held in a 64 x 64-bit
// RAM; per-row valid flops make the whole map read free right after reset, so
// there is no clearing pass. Items run one at a time. Allocate walks the
// bitmap from the next-fit offset a word at a time (RAM read, then a
// priority scan of that word); a used page restarts the run just past it, and
// the walk wraps to page 0 once. Marking the run costs a read-modify-write
// per word touched. Free first checks its address and range, then clears
// the run with a read-modify-write per word. Each item also passes through
// decode and response states. A finished result sits in the output register
// while the next item starts. Config writes are taken every cycle and must
// only arrive while idle.
module bitmap_page_allocator import bpa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                opcode_i,
  input  logic [CountW-1:0]   page_count_i,
  input  logic [AddrW-1:0]    phys_address_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [StatusW-1:0]  status_o,
  output logic [AddrW-1:0]    run_addr_o
);

  bpa_cmd_t  cmd;
  bpa_stat_t stat;

  assign cfg_ready_o = 1'b1;

  bpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bpa_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .opcode_i       (opcode_i),
    .page_count_i   (page_count_i),
    .phys_address_i (phys_address_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .run_addr_o     (run_addr_o),
    .cmd_i          (cmd),
    .stat_o         (stat)
  );

endmodule

>>> src/bpa_ram.sv
module bpa_ram #(
  parameter int Width = 64,
  parameter int Depth = 64,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/bpa_ctrl.sv
module bpa_ctrl import bpa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  bpa_stat_t stat_i,
  output bpa_cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DECODE   = 8'b0000_0010,
    S_CHECK    = 8'b0000_0100,
    S_SCAN     = 8'b0000_1000,
    S_FREE_CHK = 8'b0001_0000,
    S_MARK_RD  = 8'b0010_0000,
    S_MARK_WR  = 8'b0100_0000,
    S_RESP     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.res_code = RES_OK_ALLOC;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.op_free) begin
          cmd_o.calc_rel = 1'b1;
          state_d        = S_FREE_CHK;
        end else if (stat_i.n_ge_total) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = RES_NO_SPACE;
          state_d        = S_RESP;
        end else begin
          cmd_o.init_alloc = 1'b1;
          state_d          = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.fits) begin
          if (stat_i.ptr_lt_end) begin
            cmd_o.rd = 1'b1;
            state_d  = S_SCAN;
          end else begin
            cmd_o.init_mark = 1'b1;
            state_d         = S_MARK_RD;
          end
        end else if (stat_i.wrap_ok) begin
          cmd_o.wrap = 1'b1;
        end else begin
          cmd_o.save_off = 1'b1;
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = RES_NO_SPACE;
          state_d        = S_RESP;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        state_d         = S_CHECK;
      end
      S_FREE_CHK: begin
        if (stat_i.misaligned) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = RES_MISALIGNED;
          state_d        = S_RESP;
        end else if (stat_i.out_of_range) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = RES_RANGE;
          state_d        = S_RESP;
        end else begin
          cmd_o.init_free = 1'b1;
          state_d         = S_MARK_RD;
        end
      end
      S_MARK_RD: begin
        if (stat_i.ptr_lt_end) begin
          cmd_o.rd = 1'b1;
          state_d  = S_MARK_WR;
        end else begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = stat_i.op_free ? RES_OK_FREE : RES_OK_ALLOC;
          state_d        = S_RESP;
        end
      end
      S_MARK_WR: begin
        cmd_o.wr = 1'b1;
        state_d  = S_MARK_RD;
      end
      S_RESP: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/bpa_dp.sv
module bpa_dp import bpa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                opcode_i,
  input  logic [CountW-1:0]   page_count_i,
  input  logic [AddrW-1:0]    phys_address_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [StatusW-1:0]  status_o,
  output logic [AddrW-1:0]    run_addr_o,
  input  bpa_cmd_t            cmd_i,
  output bpa_stat_t           stat_o
);

  function automatic logic [WordW-1:0] range_mask(logic [BitIdxW-1:0] lo,
                                                  logic [BitIdxW-1:0] hi);
    logic [WordW-1:0] m;
    m = '0;
    for (int j = 0; j < WordW; j++) begin
      m[WordW-1-j] = (BitIdxW'(j) >= lo) && (BitIdxW'(j) <= hi);
    end
    return m;
  endfunction

  // first page in page order; page j of a word sits at bit WordW-1-j
  function automatic logic [BitIdxW-1:0] first_page(logic [WordW-1:0] w);
    logic [BitIdxW-1:0] r;
    r = '0;
    for (int j = WordW - 1; j >= 0; j--) begin
      if (w[WordW-1-j]) begin
        r = BitIdxW'(j);
      end
    end
    return r;
  endfunction

  logic [FrameW-1:0]   sfr_q;
  logic [CountW-1:0]   tot_q;
  logic [CountW-1:0]   soff_q;
  logic                op_q;
  logic [CountW-1:0]   n_q;
  logic [AddrW-1:0]    addr_q;
  logic [CountW-1:0]   off_q;
  logic [CountW-1:0]   ptr_q;
  logic                wrap_q;
  logic                below_q;
  logic [FrameW-1:0]   rel_q;
  logic [MapWords-1:0] row_valid_q;
  logic                rd_valid_q;
  logic                out_valid_q;
  logic [StatusW-1:0]  status_q;
  logic [AddrW-1:0]    base_q;
  logic [StatusW-1:0]  res_status_q;
  logic [AddrW-1:0]    res_base_q;

  logic [CountW-1:0]   eff_total;
  logic [EndW-1:0]     end_w;
  logic [EndW-1:0]     end_m1;
  logic [WordIdxW-1:0] ptr_word;
  logic                same_word;
  logic [BitIdxW-1:0]  hi;
  logic [WordW-1:0]    mask;
  logic [WordW-1:0]    rdata;
  logic [WordW-1:0]    word;
  logic [WordW-1:0]    hits;
  logic                hit;
  logic [CountW-1:0]   hit_next;
  logic [CountW-1:0]   next_ptr;
  logic [WordW-1:0]    wdata;
  logic [FrameW:0]     rel_sum;
  logic [FrameW-1:0]   frame;
  logic [FrameW:0]     base_sum;

  assign eff_total = (tot_q > CountW'(MaxPages)) ? CountW'(MaxPages) : tot_q;
  assign end_w     = EndW'(off_q) + EndW'(n_q);
  assign end_m1    = end_w - EndW'(1);
  assign ptr_word  = ptr_q[PageIdxW-1:BitIdxW];
  assign same_word = (end_m1[PageIdxW-1:BitIdxW] == ptr_word);
  assign hi        = same_word ? end_m1[BitIdxW-1:0] : {BitIdxW{1'b1}};
  assign mask      = range_mask(ptr_q[BitIdxW-1:0], hi);
  assign word      = rd_valid_q ? rdata : '0;
  assign hits      = word & mask;
  assign hit       = |hits;
  assign hit_next  = CountW'({ptr_word, first_page(hits)}) + CountW'(1);
  assign next_ptr  = same_word ? end_w[CountW-1:0]
                   : (CountW'({ptr_word, {BitIdxW{1'b0}}}) + CountW'(WordW));
  assign wdata     = (op_q == OP_FREE) ? (word & ~mask) : (word | mask);
  assign frame     = addr_q[AddrW-1:PageShift];
  assign rel_sum   = {1'b0, rel_q} + (FrameW+1)'(n_q);
  assign base_sum  = {1'b0, sfr_q} + (FrameW+1)'(off_q);

  bpa_ram #(
    .Width (WordW),
    .Depth (MapWords)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr),
    .waddr_i (ptr_word),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (ptr_word),
    .rdata_o (rdata)
  );

  always_comb begin
    stat_o              = '0;
    stat_o.op_free      = (op_q == OP_FREE);
    stat_o.n_ge_total   = (n_q >= eff_total);
    stat_o.fits         = (end_w <= EndW'(eff_total));
    stat_o.ptr_lt_end   = (EndW'(ptr_q) < end_w);
    stat_o.wrap_ok      = wrap_q;
    stat_o.misaligned   = (addr_q[PageShift-1:0] != '0);
    stat_o.out_of_range = below_q || (rel_sum > (FrameW+1)'(eff_total));
    stat_o.out_busy     = out_valid_q && !out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sfr_q       <= '0;
      tot_q       <= CountW'(MaxPages);
      soff_q      <= '0;
      row_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_START_FRAME: sfr_q <= cfg_data_i[FrameW-1:0];
          CFG_TOTAL_PAGES: tot_q <= cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.save_off) begin
        soff_q <= off_q;
      end else if (cmd_i.init_mark) begin
        soff_q <= end_w[CountW-1:0];
      end
      if (cmd_i.wr) begin
        row_valid_q[ptr_word] <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      n_q    <= page_count_i;
      addr_q <= phys_address_i;
    end
    if (cmd_i.calc_rel) begin
      below_q <= (frame < sfr_q);
      rel_q   <= frame - sfr_q;
    end
    if (cmd_i.rd) begin
      rd_valid_q <= row_valid_q[ptr_word];
    end
    if (cmd_i.init_alloc) begin
      off_q  <= soff_q;
      ptr_q  <= soff_q;
      wrap_q <= 1'b1;
    end else if (cmd_i.wrap) begin
      off_q  <= '0;
      ptr_q  <= '0;
      wrap_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      if (hit) begin
        off_q <= hit_next;
        ptr_q <= hit_next;
      end else begin
        ptr_q <= next_ptr;
      end
    end else if (cmd_i.init_mark) begin
      ptr_q <= off_q;
    end else if (cmd_i.init_free) begin
      off_q <= rel_q[CountW-1:0];
      ptr_q <= rel_q[CountW-1:0];
    end else if (cmd_i.wr) begin
      ptr_q <= next_ptr;
    end
    if (cmd_i.res_set) begin
      res_base_q <= (cmd_i.res_code == RES_OK_ALLOC)
                  ? {base_sum[AddrW-PageShift-1:0], {PageShift{1'b0}}} : '0;
      case (cmd_i.res_code)
        RES_OK_ALLOC:   res_status_q <= ST_OK;
        RES_OK_FREE:    res_status_q <= ST_OK;
        RES_NO_SPACE:   res_status_q <= ST_NO_SPACE;
        RES_MISALIGNED: res_status_q <= ST_MISALIGNED;
        default:        res_status_q <= ST_RANGE;
      endcase
    end
    if (cmd_i.out_load) begin
      status_q <= res_status_q;
      base_q   <= res_base_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign run_addr_o  = base_q;

endmodule

>>> test/bitmap_page_allocator_test.sv
`timescale 1ns / 100ps

module bitmap_page_allocator_test;
  import bpa_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_3 = 2'd3;
  localparam logic [AddrW-1:0]   AddrOnes    = '1;

  typedef struct {
    opcode_e           op;
    int unsigned       count;
    logic [AddrW-1:0]  addr;
  } page_req_t;

  typedef struct {
    status_e           status;
    logic [AddrW-1:0]  base;
  } page_result_t;

  typedef struct {
    logic [AddrW-1:0]  addr;
    int unsigned       count;
  } page_run_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready_o;
  logic                opcode = 1'b0;
  logic [CountW-1:0]   page_count = '0;
  logic [AddrW-1:0]    phys_address = '0;
  logic                out_valid_o;
  logic                out_ready = 1'b0;
  logic [StatusW-1:0]  status_o;
  logic [AddrW-1:0]    run_addr_o;

  bitmap_page_allocator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode),
    .page_count_i   (page_count),
    .phys_address_i (phys_address),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .status_o       (status_o),
    .run_addr_o     (run_addr_o)
  );

  // allocator state mirror
  logic [MaxPages-1:0] page_busy = '0;
  int unsigned         next_fit = 0;
  logic [FrameW-1:0]   cur_start = '0;
  logic [CountW-1:0]   cur_total_raw = CountW'(MaxPages);

  page_req_t    request_queue[$];
  page_result_t pending_results[$];
  page_run_t    held_runs[$];
  page_req_t    cur_req;
  int unsigned  idle_pct = 14;
  int unsigned  mismatches = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned usable_pages();
    return (cur_total_raw > MaxPages) ? MaxPages : int'(cur_total_raw);
  endfunction

  function automatic logic [AddrW-1:0] page_addr(longint unsigned rel);
    logic [63:0] wide;
    wide = (64'(cur_start) + rel) << PageShift;
    return wide[AddrW-1:0];
  endfunction

  function automatic page_result_t take_run(int unsigned n);
    page_result_t res;
    page_run_t    run;
    int unsigned  total, off, scan;
    bit           can_wrap, hit, done;
    total = usable_pages();
    res.status = ST_NO_SPACE;
    res.base = '0;
    if (n >= total) return res;
    off = next_fit;
    scan = off;
    can_wrap = 1'b1;
    done = 1'b0;
    while (!done) begin
      if (off + n <= total) begin
        hit = 1'b0;
        while (!hit && scan < off + n) begin
          if (page_busy[scan]) begin
            off = scan + 1;
            scan = off;
            hit = 1'b1;
          end else begin
            scan++;
          end
        end
        if (!hit) done = 1'b1;
      end else if (can_wrap) begin
        off = 0;
        scan = 0;
        can_wrap = 1'b0;
      end else begin
        next_fit = off;
        return res;
      end
    end
    res.status = ST_OK;
    res.base = page_addr(off);
    for (scan = off; scan < off + n; scan++) page_busy[scan] = 1'b1;
    next_fit = off + n;
    if (n > 0) begin
      run.addr = res.base;
      run.count = n;
      held_runs.push_back(run);
    end
    return res;
  endfunction

  function automatic status_e release_run(logic [AddrW-1:0] addr, int unsigned n);
    logic [FrameW-1:0] frame;
    longint unsigned   rel;
    if (addr[PageShift-1:0] != '0) return ST_MISALIGNED;
    frame = addr[AddrW-1:PageShift];
    if (frame < cur_start) return ST_RANGE;
    rel = 64'(frame - cur_start);
    if (rel + n > usable_pages()) return ST_RANGE;
    for (longint unsigned p = rel; p < rel + n; p++) page_busy[p] = 1'b0;
    return ST_OK;
  endfunction

  function automatic page_result_t serve_request(page_req_t r);
    page_result_t res;
    if (r.op == OP_ALLOC) begin
      res = take_run(r.count);
    end else begin
      res.status = release_run(r.addr, r.count);
      res.base = '0;
    end
    return res;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      opcode <= 1'b0;
      page_count <= '0;
      phys_address <= '0;
    end else begin
      if (in_valid && in_ready_o) pending_results.push_back(serve_request(cur_req));
      if (!in_valid || in_ready_o) begin
        if (request_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cur_req = request_queue.pop_front();
          in_valid <= 1'b1;
          opcode <= cur_req.op;
          page_count <= CountW'(cur_req.count);
          phys_address <= cur_req.addr;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    page_result_t exp_res;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with none expected: status %0d addr %h",
                   $time, status_o, run_addr_o);
          mismatches++;
        end else begin
          exp_res = pending_results.pop_front();
          if (status_o !== exp_res.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_res.status, status_o);
            mismatches++;
          end
          if (run_addr_o !== exp_res.base) begin
            $display("%0t: run_addr expected %h actual %h",
                     $time, exp_res.base, run_addr_o);
            mismatches++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic push_req(opcode_e op, int unsigned count, logic [AddrW-1:0] addr);
    page_req_t r;
    r.op = op;
    r.count = count;
    r.addr = addr;
    while (request_queue.size() >= 4) @(posedge clk_i);
    request_queue.push_back(r);
  endtask

  task automatic drain();
    while (request_queue.size() > 0 || in_valid || pending_results.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_START_FRAME: cur_start = data;
      CFG_TOTAL_PAGES: cur_total_raw = data[CountW-1:0];
      default: ;
    endcase
  endtask

  task automatic random_req();
    page_run_t        run;
    int unsigned      total, roll, sub, idx, rel, n, k;
    logic [AddrW-1:0] addr;
    total = usable_pages();
    roll = $urandom_range(99);
    sub = $urandom_range(99);
    addr = AddrW'({$urandom(), $urandom()});
    if (roll < 55 || (roll < 85 && held_runs.size() == 0)) begin
      if (sub < 80) n = $urandom_range(total / 16 + 2, 0);
      else if (sub < 95) n = $urandom_range(total, 0);
      else n = $urandom_range(MaxPages, 0);
      push_req(OP_ALLOC, n, addr);
    end else if (roll < 85) begin
      idx = $urandom_range(held_runs.size() - 1, 0);
      run = held_runs[idx];
      held_runs.delete(idx);
      n = (sub < 25) ? $urandom_range(run.count, 0) : run.count;
      push_req(OP_FREE, n, run.addr);
    end else begin
      rel = $urandom_range(total, 0);
      case (sub % 5)
        0: push_req(OP_FREE, $urandom_range(4, 0),
                    page_addr(rel) | AddrW'($urandom_range((1 << PageShift) - 1, 1)));
        1: push_req(OP_FREE, $urandom_range(total - rel, 0), page_addr(rel));
        2: begin
          n = total - rel + 1 + $urandom_range(8, 0);
          push_req(OP_FREE, (n > MaxPages) ? MaxPages : n, page_addr(rel));
        end
        3: begin
          k = $urandom_range(64, 1);
          addr = (64'(cur_start) >= k) ? page_addr(0) - (AddrW'(k) << PageShift) : '0;
          push_req(OP_FREE, $urandom_range(8, 0), addr);
        end
        default: begin
          if (sub[0]) addr[PageShift-1:0] = '0;
          push_req(OP_FREE, $urandom_range(MaxPages, 0), addr);
        end
      endcase
    end
  endtask

  task automatic run_phase(logic [CfgDataW-1:0] start, logic [CountW-1:0] total,
                           int unsigned items, bit clear_first);
    logic [CfgDataW-1:0] data;
    drain();
    data = CfgDataW'({$urandom(), $urandom()});
    data[CountW-1:0] = total;
    write_reg(CFG_START_FRAME, start);
    write_reg(CFG_TOTAL_PAGES, data);
    held_runs.delete();
    if (clear_first) push_req(OP_FREE, usable_pages(), page_addr(0));
    for (int i = 0; i < items; i++) random_req();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset configuration: start frame 0, all 4096 pages
    push_req(OP_ALLOC, 0, '0);
    push_req(OP_ALLOC, 1, AddrOnes);
    push_req(OP_ALLOC, MaxPages, '0);
    push_req(OP_ALLOC, MaxPages - 1, '0);
    push_req(OP_ALLOC, 64, '0);
    push_req(OP_ALLOC, 3000, '0);
    push_req(OP_ALLOC, 2000, '0);
    push_req(OP_FREE, 1, AddrW'(48'h801));
    push_req(OP_FREE, 1, AddrW'(MaxPages) << PageShift);
    push_req(OP_FREE, 0, AddrOnes << PageShift);
    push_req(OP_FREE, 0, '0);
    push_req(OP_FREE, 64, AddrW'(1) << PageShift);
    push_req(OP_FREE, 64, AddrW'(1) << PageShift);
    push_req(OP_ALLOC, 1, '0);
    push_req(OP_ALLOC, 1030, '0);
    push_req(OP_ALLOC, 0, '0);
    push_req(OP_ALLOC, 1, '0);
    push_req(OP_FREE, MaxPages, '0);
    push_req(OP_ALLOC, MaxPages - 1, '0);
    push_req(OP_FREE, 1, AddrW'(48'h8000_0000_0001));
    push_req(OP_FREE, MaxPages, AddrW'(1) << PageShift);
    push_req(OP_ALLOC, 8, AddrOnes);

    run_phase(36'h123, 13'd64, 80, 1'b1);
    run_phase('1, 13'd100, 70, 1'b0);
    run_phase('0, 13'd0, 20, 1'b0);
    drain();
    idle_pct = 0;
    run_phase(CfgDataW'({$urandom(), $urandom()}), 13'd8191, 90, 1'b1);
    drain();
    idle_pct = 14;
    run_phase(CfgDataW'({$urandom(), $urandom()}), 13'd1, 30, 1'b0);
    drain();
    write_reg(CFG_SPARE_2, '1);
    write_reg(CFG_SPARE_3, '1);
    run_phase(36'd5, 13'd4096, 80, 1'b1);
    run_phase(CfgDataW'({$urandom(), $urandom()}), CountW'($urandom_range(300, 1)), 60, 1'b0);

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("bitmap_page_allocator_test passed");
    end else begin
      $display("bitmap_page_allocator_test failed");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("bitmap_page_allocator_test failed");
    $finish;
  end

endmodule

>>> bitmap_page_allocator.f
src/bpa_pkg.sv
src/bpa_ram.sv
src/bpa_ctrl.sv
src/bpa_dp.sv
src/bitmap_page_allocator.sv
test/bitmap_page_allocator_test.sv
